// ----- hw/rtl/etf_pkg.sv -----
// ----------------------------------------------------------------------------
// etf_pkg: shared types and constants of the Ethernet transmit framer
// Holds frame position codes, register indexes, the CRC control bundle and
// the one-byte reflected CRC-32 update.
// ----------------------------------------------------------------------------
package etf_pkg;

	localparam int unsigned POS_W = 5;
	typedef logic [POS_W-1:0] pos_t;

	// Frame positions of the byte sequence that one item can produce
	localparam pos_t POS_HDR_FIRST = 5'd0;
	localparam pos_t POS_PAYLOAD   = 5'd14;
	localparam pos_t POS_FCS_FIRST = 5'd15;
	localparam pos_t POS_FCS_LAST  = 5'd18;

	localparam int unsigned HDR_BYTES = 14;
	localparam int unsigned FCS_BYTES = 4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_DEST_MAC   = 2'd0;
	localparam cfg_idx_t CFG_SRC_MAC    = 2'd1;
	localparam cfg_idx_t CFG_ETHER_TYPE = 2'd2;

	localparam logic [47:0] DEST_MAC_RST   = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] SRC_MAC_RST    = 48'h0000_0000_0000;
	localparam logic [15:0] ETHER_TYPE_RST = 16'h0800;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	// Control from the sequencer to the CRC unit
	typedef struct packed {
		logic upd;
		logic clr;
	} crc_ctl_t;

	// Advance the reflected CRC-32 by one byte, LSB first
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/etf_crc.sv -----
// ----------------------------------------------------------------------------
// etf_crc: running CRC-32 over transmitted header and payload bytes
// Updates once per byte, restarts at all ones on request.
// ----------------------------------------------------------------------------
module etf_crc (
	input  logic              clk,
	input  logic              arst_n,
	input  etf_pkg::crc_ctl_t ctl,
	input  logic [7:0]        data,
	output logic [31:0]       crc
);
	import etf_pkg::*;

	logic [31:0] crc_q;

	// Hold, advance by one byte, or restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ONES;
		end else if (ctl.clr) begin
			crc_q <= CRC_ONES;
		end else if (ctl.upd) begin
			crc_q <= crc32_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

// ----- hw/rtl/ethernet_tx_framer_crc32_unit.sv -----
// ----------------------------------------------------------------------------
// ethernet_tx_framer_crc32_unit: Ethernet transmit framer with FCS
// Prepends the 14-byte header to each frame's payload and appends the
// reflected CRC-32 frame check sequence, low byte first.
// ----------------------------------------------------------------------------
// Timing: an accepted item is registered in the input stage, and its bytes then
// leave through the output register at one byte per cycle while out_stall is low.
// An item holds the input stage while it emits 1 byte mid-frame, 15 on a frame's
// first byte, 5 on its last byte and 19 on a one-byte frame; mid-frame bytes stream at one per cycle unless stalled.
// Reset: the block awaits a frame start, the CRC is all ones and the
// registers hold broadcast destination, zero source MAC and ethertype 0x0800.
module ethernet_tx_framer_crc32_unit (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  etf_pkg::cfg_idx_t   cfg_index,
	input  logic [47:0]         cfg_data,
	// payload byte input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	// frame byte output
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          frame_byte,
	output logic                end_of_frame
);
	import etf_pkg::*;

	// Configuration registers
	logic [47:0] dest_mac_q;
	logic [47:0] src_mac_q;
	logic [15:0] ether_type_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_mac_q   <= DEST_MAC_RST;
			src_mac_q    <= SRC_MAC_RST;
			ether_type_q <= ETHER_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEST_MAC:   dest_mac_q   <= cfg_data;
				CFG_SRC_MAC:    src_mac_q    <= cfg_data;
				CFG_ETHER_TYPE: ether_type_q <= cfg_data[15:0];
				default:        ;
			endcase
		end
	end

	// Input stage and sequencer state
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	pos_t       pos_q;

	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       eof_q;

	logic       adv;
	logic       emit;
	logic       done;
	pos_t       end_pos;
	logic       in_take;

	assign adv     = !out_valid_q || !out_stall;
	assign emit    = valid_s1 && adv;
	assign end_pos = last_s1 ? POS_FCS_LAST : POS_PAYLOAD;
	assign done    = emit && (pos_q == end_pos);
	assign in_stall = valid_s1 && !done;
	assign in_take  = in_valid && !in_stall;

	// Load a new transaction as the held one finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Advance through the frame; restart at the header after the last FCS byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR_FIRST;
		end else if (done) begin
			pos_q <= last_s1 ? POS_HDR_FIRST : POS_PAYLOAD;
		end else if (emit) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// CRC over header and payload
	crc_ctl_t    crc_ctl;
	logic [31:0] crc;
	logic [7:0]  next_byte;

	assign crc_ctl.upd = emit && (pos_q <= POS_PAYLOAD);
	assign crc_ctl.clr = emit && (pos_q == POS_FCS_LAST);

	etf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (next_byte),
		.crc    (crc)
	);

	// Select the byte for the current position
	logic [HDR_BYTES-1:0][7:0] hdr_bytes;
	logic [FCS_BYTES-1:0][7:0] fcs_bytes;
	logic [3:0]                hdr_idx;
	logic [1:0]                fcs_idx;
	pos_t                      fcs_off;

	assign hdr_bytes = {dest_mac_q, src_mac_q, ether_type_q};
	assign fcs_bytes = ~crc;
	assign hdr_idx   = 4'(HDR_BYTES - 1) - pos_q[3:0];
	assign fcs_off   = pos_q - POS_FCS_FIRST;
	assign fcs_idx   = fcs_off[1:0];

	always_comb begin
		priority if (pos_q < POS_PAYLOAD) begin
			next_byte = hdr_bytes[hdr_idx];
		end else if (pos_q == POS_PAYLOAD) begin
			next_byte = data_s1;
		end else begin
			next_byte = fcs_bytes[fcs_idx];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_byte_q <= next_byte;
			eof_q        <= (pos_q == POS_FCS_LAST);
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = frame_byte_q;
	assign end_of_frame = eof_q;

endmodule

// ----- bench/tb_ethernet_tx_framer_crc32_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ethernet_tx_framer_crc32_unit: self-checking bench of the Ethernet framer
// Streams payload frames with random gaps and output stalls, rewrites the
// header registers between phases and checks every frame byte and the end
// of frame mark against a built-in header and CRC-32 predictor.
// ----------------------------------------------------------------------------
module tb_ethernet_tx_framer_crc32_unit;

	import etf_pkg::*;

	localparam int unsigned ITEM_TARGET  = 380;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 25;
	localparam int unsigned GAP_MAX      = 4;

	// Index with no register behind it; writes there must be dropped
	localparam cfg_idx_t CFG_IDX_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} payload_item_t;

	typedef struct packed {
		logic [7:0] fbyte;
		logic       eof;
	} frame_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_DEST_MAC;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  frame_byte;
	logic        end_of_frame;

	ethernet_tx_framer_crc32_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame)
	);

	// Header register shadow and framer state of the predictor
	logic [47:0] hdr_dest_mac   = DEST_MAC_RST;
	logic [47:0] hdr_src_mac    = SRC_MAC_RST;
	logic [15:0] hdr_ether_type = ETHER_TYPE_RST;
	logic        open_frame     = 1'b0;
	logic [31:0] running_crc    = CRC_ONES;

	payload_item_t payload_pending[$];
	frame_out_t    frame_bytes_due[$];
	int            bytes_outstanding = 0;
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   in_gap_max = GAP_MAX;
	int unsigned   out_gap_max = GAP_MAX;
	int unsigned   in_wait = 0;
	int unsigned   out_wait = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Reflected CRC-32, one input bit per round
	function automatic logic [31:0] fcs_advance(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[k];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	task automatic emit_byte(input logic [7:0] b, input logic eof, input logic into_fcs);
		frame_out_t r;
		r.fbyte = b;
		r.eof = eof;
		frame_bytes_due.push_back(r);
		if (into_fcs)
			running_crc = fcs_advance(running_crc, b);
	endtask

	// Work out the frame bytes caused by one accepted payload byte
	task automatic predict_frame_bytes(input logic [7:0] b, input logic last);
		logic [111:0] hdr;
		logic [31:0]  fcs;
		if (!open_frame) begin
			running_crc = CRC_ONES;
			hdr = {hdr_dest_mac, hdr_src_mac, hdr_ether_type};
			for (int i = 0; i < HDR_BYTES; i++)
				emit_byte(hdr[111 - 8 * i -: 8], 1'b0, 1'b1);
			open_frame = 1'b1;
		end
		emit_byte(b, 1'b0, 1'b1);
		if (last) begin
			fcs = ~running_crc;
			for (int i = 0; i < FCS_BYTES; i++)
				emit_byte(fcs[8 * i +: 8], i == FCS_BYTES - 1, 1'b0);
			running_crc = CRC_ONES;
			open_frame = 1'b0;
		end
	endtask

	// Payload driver: present queued bytes, hold while stalled, idle at random
	always @(posedge clk or negedge arst_n) begin : payload_driver
		payload_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_wait <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				predict_frame_bytes(data_byte, last_byte);
				bytes_outstanding--;
			end
			if (in_wait != 0) begin
				in_wait <= in_wait - 1;
				in_valid <= 1'b0;
			end else if (payload_pending.size() != 0) begin
				it = payload_pending.pop_front();
				in_valid <= 1'b1;
				data_byte <= it.data;
				last_byte <= it.last;
				in_wait <= $urandom_range(0, in_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: check each accepted frame byte, stall at random
	always @(posedge clk or negedge arst_n) begin : result_monitor
		frame_out_t  want;
		int unsigned w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_wait <= 0;
		end else begin
			w = out_wait;
			if (out_valid && !out_stall) begin
				if (frame_bytes_due.size() == 0) begin
					$error("unexpected frame byte %02h (end_of_frame %0b)",
						frame_byte, end_of_frame);
					fail_count++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (frame_byte !== want.fbyte) begin
						$error("frame_byte: expected %02h, got %02h", want.fbyte, frame_byte);
						fail_count++;
					end
					if (end_of_frame !== want.eof) begin
						$error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
						fail_count++;
					end
				end
				w = $urandom_range(0, out_gap_max);
			end
			if (w != 0) begin
				out_stall <= 1'b1;
				out_wait <= w - 1;
			end else begin
				out_stall <= 1'b0;
				out_wait <= 0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ethernet_tx_framer_crc32_unit verification failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		payload_item_t it;
		it.data = b;
		it.last = last;
		bytes_outstanding++;
		payload_pending.push_back(it);
	endtask

	// Wait until every byte is taken and every frame byte has come out
	task automatic wait_idle();
		do @(posedge clk);
		while (bytes_outstanding != 0 || frame_bytes_due.size() != 0);
	endtask

	// Write one register; the caller lowers cfg_valid after its batch
	task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_DEST_MAC:   hdr_dest_mac = value;
			CFG_SRC_MAC:    hdr_src_mac = value;
			CFG_ETHER_TYPE: hdr_ether_type = value[15:0];
			default: ;
		endcase
	endtask

	function automatic logic [47:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	// Stimulus: directed frames, then random phases with register rewrites
	initial begin : stimulus
		int unsigned queued;
		int unsigned n_frames;
		int unsigned len;
		logic        frame_left_open;
		logic        wrote;

		queued = 0;
		frame_left_open = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset header: single-byte frame, then a short frame with extreme bytes
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h01, 1'b1);
		wait_idle();

		// Extreme registers; ethertype written with wide data, spare index dropped
		write_reg(CFG_DEST_MAC, 48'h0000_0000_0000);
		write_reg(CFG_SRC_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_ETHER_TYPE, 48'hABCD_EF12_0000);
		write_reg(CFG_IDX_SPARE, 48'h5A5A_A5A5_0F0F);
		cfg_valid <= 1'b0;
		queue_byte(8'h55, 1'b0);
		queue_byte(8'hAA, 1'b1);
		queue_byte(8'h7F, 1'b0);
		wait_idle();

		// Rewrite in the middle of a frame: only the next header changes
		write_reg(CFG_DEST_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_SRC_MAC, 48'h0000_0000_0000);
		write_reg(CFG_ETHER_TYPE, 48'hFFFF_FFFF_FFFF);
		cfg_valid <= 1'b0;
		queue_byte(8'hFE, 1'b1);
		queue_byte(8'h12, 1'b1);
		wait_idle();

		// Random phases
		while (queued < ITEM_TARGET) begin
			wrote = 1'b0;
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_DEST_MAC, pick_reg_value());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_SRC_MAC, pick_reg_value());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_ETHER_TYPE, pick_reg_value());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 5) == 0) begin
				write_reg(CFG_IDX_SPARE, pick_reg_value());
				wrote = 1'b1;
			end
			if (wrote)
				cfg_valid <= 1'b0;
			in_gap_max = $urandom_range(0, 2) == 0 ? 0 : GAP_MAX;
			out_gap_max = $urandom_range(0, 2) == 0 ? 0 : GAP_MAX;
			n_frames = $urandom_range(1, 6);
			for (int f = 0; f < n_frames; f++) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8);
				frame_left_open = (f == n_frames - 1) && ($urandom_range(0, 3) == 0);
				for (int i = 0; i < len; i++)
					queue_byte(8'($urandom_range(0, 255)),
						(i == len - 1) && !frame_left_open);
				queued += len;
			end
			wait_idle();
		end

		// Close a frame left open by the last phase
		if (frame_left_open)
			queue_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ethernet_tx_framer_crc32_unit verification clean");
		else
			$display("ethernet_tx_framer_crc32_unit verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/etf_pkg.sv
hw/rtl/etf_crc.sv
hw/rtl/ethernet_tx_framer_crc32_unit.sv
bench/tb_ethernet_tx_framer_crc32_unit.sv
